[hw/rtl/sgpg_pkg.sv]
// ============================================================================
// Sparkle grid pixel generator package
// Shared constants, controller/datapath interface structs and small helper
// functions for the pixel generator.
// ============================================================================
package sgpg_pkg;

    // Default raster size
    localparam int DEF_WIDTH  = 16;
    localparam int DEF_HEIGHT = 16;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 9;
    localparam int SEED_W  = 32;
    localparam int COORD_W = 4;
    localparam int COLOR_W = 8;

    // Register indexes on the register port
    localparam logic REG_SPEED = 1'b0;
    localparam logic REG_PHASE = 1'b1;

    // Frame time scaling: time * speed / 100 is formed as
    // (time / 100) * speed + ((time mod 100) * speed) / 100.
    localparam int QUOT_W = 26;   // width of time / 100
    localparam int TREM_W = 7;    // width of time mod 100
    localparam int BS_W   = 16;   // width of (time mod 100) * speed
    localparam logic [TREM_W-1:0] DIVISOR = 7'd100;

    // time / 100 = ((time >> 2) * RECIP_25) >> 35, exact for any 32-bit time
    localparam logic [30:0] RECIP_25 = 31'd1374389535;
    // x / 100 = (x * RECIP_100) >> 23, exact for any 16-bit x
    localparam logic [16:0] RECIP_100 = 17'd83887;

    // Steps of the scaling sequence after the first multiply
    localparam int DIV_STEPS = 3;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Seed hashing constants
    localparam logic [SEED_W-1:0] SEED_MIX = 32'hA53C9E3D;
    localparam logic [SEED_W-1:0] GOLDEN   = 32'd2654435761;

    // Brightness levels
    localparam logic [7:0] LVL_GRID    = 8'd40;
    localparam logic [7:0] LVL_DIM     = 8'd8;
    localparam logic [7:0] LVL_FLASH   = 8'd255;
    localparam logic [7:0] LVL_SPARKLE = 8'd120;

    // Exact division by 255 for 16-bit values: (x * 0x8081) >> 23
    localparam logic [15:0] RECIP_255 = 16'h8081;

    // Command bundle from controller to datapath
    typedef struct packed {
        logic load;      // input transfer accepted, capture payload
        logic scale;     // frame time over 100 by reciprocal multiplication
        logic div_step;  // one step of the remaining time scaling
        logic hash;      // multiply scaled time by the golden constant
        logic seed;      // form the new seed, restart the raster
        logic pix1;      // advance random word, brightness and hue split
        logic pix2;      // channel products
        logic pix3;      // divide by 255, write the output register
    } sgpg_cmd_t;

    // Status bundle from datapath to controller
    typedef struct packed {
        logic div_last;  // final scaling step in progress
        logic out_free;  // output register can take a new pixel
    } sgpg_stat_t;

    // One step of the 13/17/5 xorshift generator
    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] r;
        r = s;
        r = r ^ (r << 13);
        r = r ^ (r >> 17);
        r = r ^ (r << 5);
        return r;
    endfunction

    // Hue sector: hue / 43
    function automatic logic [2:0] hue_region(input logic [7:0] h);
        logic [2:0] reg_val;
        if (h < 8'd43)
            reg_val = 3'd0;
        else if (h < 8'd86)
            reg_val = 3'd1;
        else if (h < 8'd129)
            reg_val = 3'd2;
        else if (h < 8'd172)
            reg_val = 3'd3;
        else if (h < 8'd215)
            reg_val = 3'd4;
        else
            reg_val = 3'd5;
        return reg_val;
    endfunction

    // Start of a hue sector: region * 43
    function automatic logic [7:0] region_base(input logic [2:0] region);
        logic [7:0] base;
        case (region)
            3'd1:    base = 8'd43;
            3'd2:    base = 8'd86;
            3'd3:    base = 8'd129;
            3'd4:    base = 8'd172;
            3'd5:    base = 8'd215;
            default: base = 8'd0;
        endcase
        return base;
    endfunction

    // Triangle wave over one 8-bit period
    function automatic logic [7:0] tri_wave(input logic [7:0] a);
        logic [7:0] lo;
        lo = {a[6:0], 1'b0};
        return a[7] ? (8'd255 - lo) : lo;
    endfunction

endpackage

[hw/rtl/sgpg_ctrl.sv]
// ============================================================================
// Sparkle grid controller
// State machine that sequences frame-start seeding and the three pixel steps,
// and handshakes the input stream.
// ============================================================================
module sgpg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_frame_start,
    output logic                 in_ready,
    input  sgpg_pkg::sgpg_stat_t stat,
    output sgpg_pkg::sgpg_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_HASH  = 3'd3;
    localparam logic [2:0] ST_SEED  = 3'd4;
    localparam logic [2:0] ST_PIX1  = 3'd5;
    localparam logic [2:0] ST_PIX2  = 3'd6;
    localparam logic [2:0] ST_PIX3  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_frame_start ? ST_SCALE : ST_PIX1;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_HASH;
            end
            ST_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = ST_PIX1;
            end
            ST_PIX1:
            begin
                cmd.pix1   = 1'b1;
                state_next = ST_PIX2;
            end
            ST_PIX2:
            begin
                cmd.pix2   = 1'b1;
                state_next = ST_PIX3;
            end
            ST_PIX3:
            begin
                // Hold here until the output register is free
                if (stat.out_free)
                begin
                    cmd.pix3   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/sgpg_datapath.sv]
// ============================================================================
// Sparkle grid datapath
// Frame time scaling by reciprocal multiplication, seed hashing, raster
// counters, per-pixel brightness and integer HSV conversion, output register.
// ============================================================================
module sgpg_datapath
#(
    parameter int WIDTH  = sgpg_pkg::DEF_WIDTH,
    parameter int HEIGHT = sgpg_pkg::DEF_HEIGHT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sgpg_pkg::sgpg_cmd_t           cmd,
    output sgpg_pkg::sgpg_stat_t          stat,
    input  logic [sgpg_pkg::TIME_W-1:0]   in_time,
    input  logic [sgpg_pkg::SPEED_W-1:0]  speed,
    input  logic [sgpg_pkg::SEED_W-1:0]   phase,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   out_data,
    output logic                          out_last
);

    localparam int XW = (WIDTH  > 1) ? $clog2(WIDTH)  : 1;
    localparam int YW = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam logic [XW-1:0] X_LAST = XW'(WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(HEIGHT - 1);

    // Scaling steps that follow the first multiply
    localparam logic [sgpg_pkg::DIV_CNT_W-1:0] DSTEP_SPLIT = 2'd0;
    localparam logic [sgpg_pkg::DIV_CNT_W-1:0] DSTEP_MUL   = 2'd1;

    // Frame-start arithmetic
    logic [sgpg_pkg::TIME_W-1:0]    time_reg;
    logic [sgpg_pkg::QUOT_W-1:0]    tq_reg;
    logic [sgpg_pkg::TREM_W-1:0]    tr_reg;
    logic [sgpg_pkg::TIME_W-1:0]    hi_reg;
    logic [sgpg_pkg::BS_W-1:0]      bs_reg;
    logic [sgpg_pkg::TIME_W-1:0]    quot_reg;
    logic [sgpg_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [sgpg_pkg::SEED_W-1:0]    hash_reg;

    // Generator state
    logic [sgpg_pkg::SEED_W-1:0]    seed_reg;
    logic [7:0]                     hue_origin_reg;
    logic [XW-1:0]                  x_reg;
    logic [YW-1:0]                  y_reg;

    // Pixel pipeline registers
    logic [7:0]  v_reg;
    logic [7:0]  rem_reg;
    logic [2:0]  region_reg;
    logic [15:0] prod_q_reg;
    logic [15:0] prod_t_reg;
    logic [7:0]  pv_reg;
    logic [2:0]  pregion_reg;

    // Output register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_last_reg;

    // Scaling products
    logic [60:0] tq_full;
    logic [31:0] tr_full;
    logic [34:0] hi_full;
    logic [32:0] frac_full;

    // Pixel step one
    logic [sgpg_pkg::SEED_W-1:0] rnd;
    logic [7:0] x8;
    logic [7:0] y8;
    logic [7:0] v_base;
    logic [7:0] v_spark;
    logic [7:0] ripple_arg;
    logic [7:0] tri_val;
    logic [7:0] ripple;
    logic [7:0] hue;
    logic [2:0] region;
    logic [7:0] rem_val;

    // Pixel step three
    logic [31:0] q_full;
    logic [31:0] t_full;
    logic [7:0]  q_val;
    logic [7:0]  t_val;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    assign stat.div_last = (div_cnt_reg == sgpg_pkg::DIV_CNT_W'(sgpg_pkg::DIV_STEPS - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    // Time over 100, time mod 100 and the two speed products
    assign tq_full   = 61'(time_reg[sgpg_pkg::TIME_W-1:2]) * 61'(sgpg_pkg::RECIP_25);
    assign tr_full   = time_reg - 32'(tq_reg) * 32'(sgpg_pkg::DIVISOR);
    assign hi_full   = 35'(tq_reg) * 35'(speed);
    assign frac_full = 33'(bs_reg) * 33'(sgpg_pkg::RECIP_100);

    // Random word, brightness and hue for the current pixel
    always_comb
    begin
        rnd = sgpg_pkg::xorshift(seed_reg);
        x8  = 8'(x_reg);
        y8  = 8'(y_reg);
        if (x8[1:0] == 2'd0 || y8[1:0] == 2'd0)
            v_base = sgpg_pkg::LVL_GRID;
        else
            v_base = sgpg_pkg::LVL_DIM;
        if (rnd[8:0] == 9'd0)
            v_spark = sgpg_pkg::LVL_FLASH;
        else if (rnd[6:0] == 7'd0)
            v_spark = sgpg_pkg::LVL_SPARKLE + {2'b00, rnd[5:0]};
        else
            v_spark = v_base;
        ripple_arg = hue_origin_reg + 8'(x8 * 8'd7) + 8'(y8 * 8'd11);
        tri_val    = sgpg_pkg::tri_wave(ripple_arg);
        ripple     = {4'd0, tri_val[7:4]};
        hue        = hue_origin_reg + {x8[6:0], 1'b0} + 8'(y8 * 8'd5);
        region     = sgpg_pkg::hue_region(hue);
        rem_val    = 8'((hue - sgpg_pkg::region_base(region)) * 8'd6);
    end

    // Divide by 255 and sector selection
    always_comb
    begin
        q_full = 32'(prod_q_reg) * 32'(sgpg_pkg::RECIP_255);
        t_full = 32'(prod_t_reg) * 32'(sgpg_pkg::RECIP_255);
        q_val  = q_full[30:23];
        t_val  = t_full[30:23];
        case (pregion_reg)
            3'd1:
            begin
                red = q_val;  green = pv_reg; blue = 8'd0;
            end
            3'd2:
            begin
                red = 8'd0;   green = pv_reg; blue = t_val;
            end
            3'd3:
            begin
                red = 8'd0;   green = q_val;  blue = pv_reg;
            end
            3'd4:
            begin
                red = t_val;  green = 8'd0;   blue = pv_reg;
            end
            3'd5:
            begin
                red = pv_reg; green = 8'd0;   blue = q_val;
            end
            default:
            begin
                red = pv_reg; green = t_val;  blue = 8'd0;
            end
        endcase
    end

    // Frame-start arithmetic and pixel pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            time_reg <= in_time;
        if (cmd.scale)
            tq_reg <= tq_full[60:35];
        if (cmd.div_step && div_cnt_reg == DSTEP_SPLIT)
        begin
            tr_reg <= tr_full[sgpg_pkg::TREM_W-1:0];
            hi_reg <= hi_full[31:0];
        end
        if (cmd.div_step && div_cnt_reg == DSTEP_MUL)
            bs_reg <= 16'(tr_reg) * 16'(speed);
        if (cmd.div_step && stat.div_last)
            quot_reg <= hi_reg + 32'(frac_full[32:23]);
        if (cmd.hash)
            hash_reg <= quot_reg * sgpg_pkg::GOLDEN;
        if (cmd.pix1)
        begin
            v_reg      <= v_spark + ripple;
            rem_reg    <= rem_val;
            region_reg <= region;
        end
        if (cmd.pix2)
        begin
            prod_q_reg  <= 16'(v_reg) * 16'(8'd255 - rem_reg);
            prod_t_reg  <= 16'(v_reg) * 16'(rem_reg);
            pv_reg      <= v_reg;
            pregion_reg <= region_reg;
        end
        if (cmd.pix3)
        begin
            out_data_reg <= {blue, green, red, y8[3:0], x8[3:0]};
            out_last_reg <= (x_reg == X_LAST) && (y_reg == Y_LAST);
        end
    end

    // Scaling step counter, generator state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg    <= '0;
            seed_reg       <= '0;
            hue_origin_reg <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.scale)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + 1'b1;

            if (cmd.hash)
                hue_origin_reg <= quot_reg[12:5];

            if (cmd.seed)
            begin
                seed_reg <= sgpg_pkg::SEED_MIX ^ (phase + hash_reg);
                x_reg    <= '0;
                y_reg    <= '0;
            end
            else if (cmd.pix1)
                seed_reg <= rnd;

            // Raster advance once the pixel is in the output register
            if (cmd.pix3)
            begin
                if (x_reg == X_LAST)
                begin
                    x_reg <= '0;
                    y_reg <= (y_reg == Y_LAST) ? '0 : y_reg + 1'b1;
                end
                else
                    x_reg <= x_reg + 1'b1;
            end

            if (cmd.pix3)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

[hw/rtl/sparkle_grid_pixel_generator.sv]
// ============================================================================
// Sparkle grid pixel generator
// One RGB pixel of a sparkle-grid LED matrix effect per input transfer, in
// raster order, with an APB-style register port for speed and phase.
// ============================================================================
// Sequencing: a transfer runs the three pixel steps into the output register; a
//   frame-start transfer first scales time by speed/100, hashes it and seeds.
//   The next transfer is taken only after the pixel is written, and the last
//   pixel step waits while the output register still holds an unaccepted pixel.
// Reset: asynchronous, active low; clears state, seed, raster position and
//   base hue, and loads speed 100 and phase 0.
module sparkle_grid_pixel_generator
#(
    parameter int WIDTH  = sgpg_pkg::DEF_WIDTH,
    parameter int HEIGHT = sgpg_pkg::DEF_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] frame_time_ms
    input  logic        s_axis_tuser,   // [0] frame_start
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] pixel_x, [7:4] pixel_y,
                                        // [15:8] red, [23:16] green, [31:24] blue
    output logic        m_axis_tlast,   // frame_last
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [sgpg_pkg::SPEED_W-1:0] SPEED_RESET = 9'd100;

    logic [sgpg_pkg::SPEED_W-1:0] speed_reg;
    logic [sgpg_pkg::SEED_W-1:0]  phase_reg;
    logic                         cfg_write;

    sgpg_pkg::sgpg_cmd_t  cmd;
    sgpg_pkg::sgpg_stat_t stat;

    // Register port: word-addressed, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_RESET;
            phase_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sgpg_pkg::REG_SPEED: speed_reg <= pwdata[sgpg_pkg::SPEED_W-1:0];
                sgpg_pkg::REG_PHASE: phase_reg <= pwdata;
                default:             ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            sgpg_pkg::REG_SPEED: prdata = 32'(speed_reg);
            sgpg_pkg::REG_PHASE: prdata = phase_reg;
            default:             prdata = '0;
        endcase
    end

    // Sequencer
    sgpg_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_frame_start (s_axis_tuser),
        .in_ready       (s_axis_tready),
        .stat           (stat),
        .cmd            (cmd)
    );

    // Arithmetic and pixel state
    sgpg_datapath
    #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_time   (s_axis_tdata),
        .speed     (speed_reg),
        .phase     (phase_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // A plain pixel transfer goes straight to the first pixel step
    a_plain_to_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> cmd.pix1)
        else $error("plain pixel did not start the pixel steps");

    // A frame-start transfer begins the time scaling
    a_start_to_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> cmd.scale)
        else $error("frame start did not begin scaling");

    // A new pixel only appears from the last pixel step
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.pix3))
        else $error("output valid without a pixel write");

    // The frame-last flag only marks the final raster position
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[3:0] == 4'(WIDTH - 1) && m_axis_tdata[7:4] == 4'(HEIGHT - 1)))
        else $error("frame last on a pixel that is not the final one");

endmodule
